FILE: hdl/rfw_pkg.sv
// Package for the rectangle fill writer.
// Holds item payload types, command and register index codes, and the
// controller/datapath interface structs. Depends on nothing.
package rfw_pkg;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd3;

  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [12:0] X_RES_RST = 13'd1024;
  localparam logic [12:0] Y_RES_RST = 13'd768;
  localparam logic [2:0]  BPP_RST   = 3'd1;

  // Input item
  typedef struct packed {
    logic        command;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic [31:0] fill_color;
  } rfw_in_t;

  // Result item
  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        last_pixel;
    logic        out_of_bounds;
  } rfw_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch a new rectangle
    logic mul;    // bounds check and row multiply
    logic scale;  // offset times bytes per pixel
    logic emit;   // load result register, advance counts
  } rfw_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_load;   // input item is a load command
    logic nonempty;  // input rectangle has area
    logic done;      // pixel in flight ends the fill
  } rfw_stat_t;

endpackage

FILE: hdl/rfw_datapath.sv
// Datapath of the rectangle fill writer: configuration registers,
// rectangle state, address arithmetic and the result register.
// Depends on rfw_pkg.
module rfw_datapath #(
  parameter int unsigned MAX_RES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rfw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rfw_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  rfw_pkg::rfw_in_t                     in_data,
  input  rfw_pkg::rfw_ctrl_t                   ctrl,
  output rfw_pkg::rfw_stat_t                   stat,
  output rfw_pkg::rfw_out_t                    out_data
);
  import rfw_pkg::*;

  localparam logic [16:0] MAX_RES_V = 17'(MAX_RES);

  // Configuration
  logic [12:0] x_res_r;
  logic [12:0] y_res_r;
  logic [2:0]  bpp_r;
  logic [31:0] base_r;

  // Rectangle state
  logic [11:0] org_x_r;
  logic [11:0] org_y_r;
  logic [12:0] span_w_r;
  logic [12:0] span_h_r;
  logic [12:0] col_r;
  logic [12:0] row_r;
  logic [31:0] color_r;

  // Pipeline registers
  logic [26:0] prod_r;
  logic [13:0] px_r;
  logic        oob_r;
  logic        last_r;
  logic        row_end_r;
  logic [29:0] scaled_r;
  rfw_out_t    out_r;

  logic [12:0] x_eff;
  logic [12:0] y_eff;
  logic [2:0]  bpp_eff;
  logic [13:0] px;
  logic [13:0] py;
  logic [13:0] col_inc;
  logic [13:0] row_inc;
  logic        oob_now;
  logic        row_end;
  logic        last_now;
  logic [26:0] prod_c;
  logic [26:0] offset_c;
  logic [29:0] scaled_c;

  // Saturate resolutions at MAX_RES
  assign x_eff = ({4'd0, x_res_r} > MAX_RES_V) ? MAX_RES_V[12:0] : x_res_r;
  assign y_eff = ({4'd0, y_res_r} > MAX_RES_V) ? MAX_RES_V[12:0] : y_res_r;

  // Force bytes per pixel into one to four
  always_comb begin
    priority if (bpp_r == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (bpp_r > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = bpp_r;
    end
  end

  // Current pixel position and end-of-row/end-of-fill tests
  assign px       = {2'd0, org_x_r} + {1'b0, col_r};
  assign py       = {2'd0, org_y_r} + {1'b0, row_r};
  assign oob_now  = (px >= {1'b0, x_eff}) || (py >= {1'b0, y_eff});
  assign col_inc  = {1'b0, col_r} + 14'd1;
  assign row_inc  = {1'b0, row_r} + 14'd1;
  assign row_end  = col_inc >= {1'b0, span_w_r};
  assign last_now = row_end && (row_inc >= {1'b0, span_h_r});

  assign prod_c   = {14'd0, x_eff} * {13'd0, py};
  assign offset_c = prod_r + {13'd0, px_r};
  assign scaled_c = {3'd0, offset_c} * {27'd0, bpp_eff};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_res_r <= X_RES_RST;
      y_res_r <= Y_RES_RST;
      bpp_r   <= BPP_RST;
      base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_RES: x_res_r <= cfg_data[12:0];
        CFG_Y_RES: y_res_r <= cfg_data[12:0];
        CFG_BPP:   bpp_r   <= cfg_data[2:0];
        CFG_BASE:  base_r  <= cfg_data[31:0];
      endcase
    end
  end

  // Rectangle latch and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (ctrl.load) begin
      col_r <= '0;
      row_r <= '0;
    end else if (ctrl.emit && !oob_r && !last_r) begin
      if (row_end_r) begin
        col_r <= '0;
        row_r <= row_inc[12:0];
      end else begin
        col_r <= col_inc[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      org_x_r  <= in_data.start_x;
      org_y_r  <= in_data.start_y;
      span_w_r <= in_data.rect_width;
      span_h_r <= in_data.rect_height;
      color_r  <= in_data.fill_color;
    end
  end

  // Multiply stage: row offset, bounds and end flags
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r    <= prod_c;
      px_r      <= px;
      oob_r     <= oob_now;
      last_r    <= last_now;
      row_end_r <= row_end;
    end
  end

  // Scale stage: pixel offset to byte offset
  always_ff @(posedge clk) begin
    if (ctrl.scale) begin
      scaled_r <= scaled_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_r.byte_count <= bpp_eff;
      if (oob_r) begin
        out_r.write_address <= '0;
        out_r.write_data    <= '0;
        out_r.last_pixel    <= 1'b1;
        out_r.out_of_bounds <= 1'b1;
      end else begin
        out_r.write_address <= base_r + {2'd0, scaled_r};
        out_r.write_data    <= color_r;
        out_r.last_pixel    <= last_r;
        out_r.out_of_bounds <= 1'b0;
      end
    end
  end

  assign out_data      = out_r;
  assign stat.is_load  = (in_data.command == CMD_LOAD);
  assign stat.nonempty = (in_data.rect_width != '0) && (in_data.rect_height != '0);
  assign stat.done     = oob_r || last_r;

endmodule

FILE: hdl/rfw_controller.sv
// Controller of the rectangle fill writer: sequences each step item through
// multiply, scale and emit, tracks the busy flag and the result valid.
// Depends on rfw_pkg.
module rfw_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rfw_pkg::rfw_stat_t  stat,
  output rfw_pkg::rfw_ctrl_t  ctrl
);
  import rfw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   busy_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   go;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign go         = accept && !stat.is_load && busy_r;
  assign ctrl.load  = accept && stat.is_load;
  assign ctrl.mul   = (state_r == ST_MUL);
  assign ctrl.scale = (state_r == ST_SCALE);
  assign ctrl.emit  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  // Next state, busy and result valid
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctrl.load) begin
          busy_nxt = stat.nonempty;
        end else if (go) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (ctrl.emit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (stat.done) begin
            busy_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // A pixel in flight always belongs to an active fill
  a_busy_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> busy_r)
    else $error("pixel in flight while fill idle");

  // Emitting a pixel presents a result next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> out_valid_r)
    else $error("emitted pixel not presented");

  // Loads and idle steps keep the sequencer idle
  a_no_spurious_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) && !go) |=> (state_r == ST_IDLE))
    else $error("sequencer left idle without a live step");

  // No new result while an earlier one still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ctrl.emit)
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: hdl/rectangle_fill_writer.sv
// Top level of the rectangle fill writer: controller plus datapath.
// Depends on rfw_pkg, rfw_controller and rfw_datapath.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  in_data   (rfw_in_t: load or step item)
//   out      out_valid / out_ready out_data (rfw_out_t: one pixel write)
//   cfg      cfg_we               cfg_index, cfg_data (write only)
//
// A load item is latched when it is accepted. A step item of an active fill
// passes through accept, 13x14 row multiply, bytes-per-pixel scale and emit;
// the three registered stages after accept are ST_MUL, ST_SCALE and ST_EMIT.
// A step while idle is accepted and does nothing.
// Emit waits while the result register still holds an untaken item; input
// is accepted again as soon as the sequencer is back in idle.
// Reset is synchronous, active low; configuration returns to its defaults.
module rectangle_fill_writer #(
  parameter int unsigned MAX_RES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rfw_pkg::rfw_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rfw_pkg::rfw_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [rfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rfw_pkg::*;

  rfw_ctrl_t ctrl;
  rfw_stat_t stat;

  // Sequencer
  rfw_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Arithmetic and storage
  rfw_datapath #(
    .MAX_RES (MAX_RES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
